[design/bsgu_pkg.sv]
// Shared types and constants for the search grid update block.
// Used by the channel interfaces and by the top-level module of the block.
package bsgu_pkg;

  localparam int FRAC = 16;            // fraction bits of Q1.16 probabilities and Q0.16 detections
  localparam int PW   = FRAC + 1;      // probability width, holds 1.0
  localparam int DW   = FRAC;          // detection width
  localparam int NW   = 2 * FRAC;      // scaled numerator width
  localparam int RW   = 2 * FRAC + 1;  // reciprocal width
  localparam int WW   = PW + DW;       // memory word: posterior and detection

  localparam logic [PW-1:0] ONE  = {1'b1, {FRAC{1'b0}}};
  localparam logic [PW-1:0] HALF = {2'b01, {(FRAC-1){1'b0}}};

  typedef logic [2:0]    coord_t;
  typedef logic [PW-1:0] prob_t;
  typedef logic [DW-1:0] det_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SUM_BAD   = 2'd1,
    ST_DET_BAD   = 2'd2,
    ST_COORD_BAD = 2'd3
  } status_t;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

endpackage

[design/bsgu_in_if.sv]
// Input channel of the search grid update block: one load or search item.
// Depends on bsgu_pkg for the field types.
interface bsgu_in_if import bsgu_pkg::*; ();
  logic   valid;
  logic   ready;
  op_t    op;
  coord_t cell_row;
  coord_t cell_col;
  prob_t  prior_value;
  det_t   detect_value;

  modport source (output valid, op, cell_row, cell_col, prior_value, detect_value,
                  input ready);
  modport sink   (input valid, op, cell_row, cell_col, prior_value, detect_value,
                  output ready);
endinterface

[design/bsgu_out_if.sv]
// Result channel of the search grid update block: one reported cell.
// Depends on bsgu_pkg for the field types.
interface bsgu_out_if import bsgu_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  out_row;
  coord_t  out_col;
  prob_t   posterior;
  prob_t   overall_detection;
  status_t status;
  logic    last;

  modport source (output valid, out_row, out_col, posterior, overall_detection, status,
                  last, input ready);
  modport sink   (input valid, out_row, out_col, posterior, overall_detection, status,
                  last, output ready);
endinterface

[design/bayes_search_grid_update_top.sv]
// Search grid update block, top level: sequencer, datapath and register port.
// Depends on bsgu_pkg, bsgu_in_if, bsgu_out_if and bsgu_ram.
//
// Usage. in_ch carries load and search items; out_ch carries reported cells;
// the APB port (psel..prdata) sets rows_in_use, cols_in_use and sum_tolerance
// at byte addresses 0, 4 and 8. Write registers only while the block is idle.
// A load writes its cell if that lies in the grid in use and returns one
// result, registered from S_LOAD once the output register is free. A search
// first reads every cell in use to check the probability sum and the
// detection values, then forms 1-p*d and its reciprocal with a bit-serial
// divider, then rewrites every cell through the memory (read, three
// multiplies, a correction and write-back). A failing check gives one result.
// The rate is set by the memory's single read port and the multiplies in turn.
// An item is taken only while the sequencer is idle; a finished result may
// still wait in the output register. If the receiver stalls, the sequencer
// holds before its next result. Reset sets rows_in_use and cols_in_use to 8,
// sum_tolerance to 4, and clears the sequencer and all detection-valid flags;
// memory contents are undefined until loaded.
module bayes_search_grid_update_top
  import bsgu_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  bsgu_in_if.sink           in_ch,
  bsgu_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int CNTW  = 7;
  localparam int SUMW  = PW + AW + 1;
  localparam int DCW   = $clog2(RW);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_LOAD     = 16'h0002,
    S_SUM_RD   = 16'h0004,
    S_SUM_ACC  = 16'h0008,
    S_CHECK    = 16'h0010,
    S_ERR      = 16'h0020,
    S_PROD     = 16'h0040,
    S_DEN      = 16'h0080,
    S_DIV      = 16'h0100,
    S_CELL_RD  = 16'h0200,
    S_CELL_NUM = 16'h0400,
    S_MUL_R    = 16'h0800,
    S_MUL_D    = 16'h1000,
    S_FIX      = 16'h2000,
    S_MUL_DET  = 16'h4000,
    S_EMIT     = 16'h8000
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [3:0] rows_r, cols_r;
  logic [7:0] tol_r;

  // Captured item
  op_t           op_r;
  coord_t        row_r, col_r;
  logic [AW-1:0] tgt_r;
  logic          inside_r;
  prob_t         pv_r;
  det_t          dv_r;

  // Walk over the cells in use
  logic [CNTW-1:0] i_r, j_r;
  logic [AW-1:0]   addr_r, row_base_r;

  // Check pass
  logic [SUMW-1:0] sum_r;
  logic            det_bad_r;
  prob_t           p_r;
  det_t            d_r;
  status_t         err_st_r;
  logic [CELLS-1:0] ok_bits_r;
  logic            ok_rd_r;

  // Update arithmetic
  logic [PW+DW-1:0] prod_pd_r;
  logic [2*PW-1:0]  prod_nt_r;
  prob_t            denom_r, numt_r;
  logic [PW-1:0]    drem_r;
  logic [RW-1:0]    recip_r;
  logic [DCW-1:0]   dcnt_r;
  logic [NW-1:0]    nn_r;
  logic             sat_r;
  det_t             cur_d_r;
  prob_t            qe_r, nv_r, acc_r;
  logic [2*PW-1:0]  qd_r;
  logic [PW+DW-1:0] nd_r;

  // Output register
  logic    o_valid_r;
  coord_t  o_row_r, o_col_r;
  prob_t   o_post_r, o_od_r;
  status_t o_st_r;
  logic    o_last_r;

  // Memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  prob_t         rd_post;
  det_t          rd_det;

  logic [CNTW-1:0] nr_eff, nc_eff;
  logic            in_inside, last_cell, slot_free;
  logic [AW-1:0]   in_tgt;
  prob_t           in_pv_sat;
  logic [SUMW-1:0] sum_nxt, sum_diff;
  logic [PW+DW:0]  pd_round;
  logic [2*PW:0]   nt_round;
  prob_t           pd_c, num_c, nv_c, contrib_c, acc_nxt;
  logic [PW:0]     rem_sh;
  logic            qbit;
  logic [NW+RW-1:0] prod_nr;
  logic [2*PW-1:0] rem_c;
  logic [PW+DW:0]  nd_round;
  logic [PW:0]     acc_sum;

  assign nr_eff = (CNTW'(rows_r) > CNTW'(MAX_ROWS)) ? CNTW'(MAX_ROWS) : CNTW'(rows_r);
  assign nc_eff = (CNTW'(cols_r) > CNTW'(MAX_COLS)) ? CNTW'(MAX_COLS) : CNTW'(cols_r);
  assign in_inside = (CNTW'(in_ch.cell_row) < nr_eff) && (CNTW'(in_ch.cell_col) < nc_eff);
  assign in_tgt = AW'(32'(in_ch.cell_row) * 32'(MAX_COLS) + 32'(in_ch.cell_col));
  assign in_pv_sat = (in_ch.prior_value > ONE) ? ONE : in_ch.prior_value;
  assign last_cell = (i_r == nr_eff - 1'b1) && (j_r == nc_eff - 1'b1);
  assign slot_free = !o_valid_r || out_ch.ready;

  assign rd_post = ram_rdata[WW-1:DW];
  assign rd_det  = ram_rdata[DW-1:0];

  // Check pass arithmetic
  assign sum_nxt  = sum_r + SUMW'(rd_post);
  assign sum_diff = (sum_r > SUMW'(ONE)) ? (sum_r - SUMW'(ONE)) : (SUMW'(ONE) - sum_r);

  // Denominator 1 - p*d and the searched cell's numerator p*(1-d), rounded
  assign pd_round = {1'b0, prod_pd_r} + (PW+DW+1)'(HALF);
  assign pd_c     = PW'(pd_round >> FRAC);
  assign nt_round = {1'b0, prod_nt_r} + (2*PW+1)'(HALF);

  // One restoring step of 2^32 / denom; the dividend has a single set bit
  assign rem_sh = {drem_r, (dcnt_r == DCW'(RW - 1))};
  assign qbit   = rem_sh >= {1'b0, denom_r};

  assign num_c   = (addr_r == tgt_r) ? numt_r : rd_post;
  assign prod_nr = {{RW{1'b0}}, nn_r} * {{NW{1'b0}}, recip_r};
  // The reciprocal estimate is low by at most one.
  assign rem_c   = {2'b00, nn_r} - qd_r;
  assign nv_c    = sat_r ? ONE :
                   ((rem_c >= {{PW{1'b0}}, denom_r}) ? (qe_r + 1'b1) : qe_r);

  assign nd_round  = {1'b0, nd_r} + (PW+DW+1)'(HALF);
  assign contrib_c = PW'(nd_round >> FRAC);
  assign acc_sum   = {1'b0, acc_r} + {1'b0, contrib_c};
  assign acc_nxt   = (acc_sum > {1'b0, ONE}) ? ONE : acc_sum[PW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {nv_c, cur_d_r};
    if (state_r == S_LOAD && slot_free && inside_r) begin
      ram_we    = 1'b1;
      ram_waddr = tgt_r;
      ram_wdata = {pv_r, dv_r};
    end else if (state_r == S_FIX) begin
      ram_we = 1'b1;
    end
  end

  bsgu_ram #(.WIDTH(WW), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = o_valid_r;
  assign out_ch.out_row           = o_row_r;
  assign out_ch.out_col           = o_col_r;
  assign out_ch.posterior         = o_post_r;
  assign out_ch.overall_detection = o_od_r;
  assign out_ch.status            = o_st_r;
  assign out_ch.last              = o_last_r;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_ROWS: prdata = {28'd0, rows_r};
      REG_COLS: prdata = {28'd0, cols_r};
      REG_TOL:  prdata = {24'd0, tol_r};
      default:  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rows_r    <= 4'd8;
      cols_r    <= 4'd8;
      tol_r     <= 8'd4;
      ok_bits_r <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_ROWS: rows_r <= pwdata[3:0];
          REG_COLS: cols_r <= pwdata[3:0];
          REG_TOL:  tol_r  <= pwdata[7:0];
          default:  ;
        endcase
      end

      if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
      ok_rd_r <= ok_bits_r[addr_r];

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r       <= in_ch.op;
            row_r      <= in_ch.cell_row;
            col_r      <= in_ch.cell_col;
            tgt_r      <= in_tgt;
            inside_r   <= in_inside;
            pv_r       <= in_pv_sat;
            dv_r       <= in_ch.detect_value;
            i_r        <= '0;
            j_r        <= '0;
            addr_r     <= '0;
            row_base_r <= '0;
            sum_r      <= '0;
            det_bad_r  <= 1'b0;
            if (in_ch.op == OP_LOAD) begin
              state_r <= S_LOAD;
            end else if (nr_eff == '0 || nc_eff == '0) begin
              state_r <= S_CHECK;
            end else begin
              state_r <= S_SUM_RD;
            end
          end
        end

        S_LOAD: begin
          if (slot_free) begin
            if (inside_r) begin
              ok_bits_r[tgt_r] <= 1'b1;
            end
            o_valid_r <= 1'b1;
            o_row_r   <= row_r;
            o_col_r   <= col_r;
            o_post_r  <= inside_r ? pv_r : '0;
            o_od_r    <= '0;
            o_st_r    <= inside_r ? ST_OK : ST_COORD_BAD;
            o_last_r  <= 1'b1;
            state_r   <= S_IDLE;
          end
        end

        S_SUM_RD: state_r <= S_SUM_ACC;

        S_SUM_ACC: begin
          sum_r <= sum_nxt;
          if (!ok_rd_r || rd_det == '0) begin
            det_bad_r <= 1'b1;
          end
          if (addr_r == tgt_r) begin
            p_r <= rd_post;
            d_r <= rd_det;
          end
          if (last_cell) begin
            state_r <= S_CHECK;
          end else begin
            if (j_r == nc_eff - 1'b1) begin
              j_r        <= '0;
              i_r        <= i_r + 1'b1;
              row_base_r <= row_base_r + AW'(MAX_COLS);
              addr_r     <= row_base_r + AW'(MAX_COLS);
            end else begin
              j_r    <= j_r + 1'b1;
              addr_r <= addr_r + 1'b1;
            end
            state_r <= S_SUM_RD;
          end
        end

        S_CHECK: begin
          if (sum_diff > SUMW'(tol_r)) begin
            err_st_r <= ST_SUM_BAD;
            state_r  <= S_ERR;
          end else if (det_bad_r) begin
            err_st_r <= ST_DET_BAD;
            state_r  <= S_ERR;
          end else if (!inside_r) begin
            err_st_r <= ST_COORD_BAD;
            state_r  <= S_ERR;
          end else begin
            state_r <= S_PROD;
          end
        end

        S_ERR: begin
          if (slot_free) begin
            o_valid_r <= 1'b1;
            o_row_r   <= row_r;
            o_col_r   <= col_r;
            o_post_r  <= '0;
            o_od_r    <= '0;
            o_st_r    <= err_st_r;
            o_last_r  <= 1'b1;
            state_r   <= S_IDLE;
          end
        end

        S_PROD: begin
          prod_pd_r <= p_r * d_r;
          prod_nt_r <= {{PW{1'b0}}, p_r} * {{PW{1'b0}}, ONE - PW'(d_r)};
          state_r   <= S_DEN;
        end

        S_DEN: begin
          denom_r    <= (pd_c >= ONE) ? PW'(1) : (ONE - pd_c);
          numt_r     <= PW'(nt_round >> FRAC);
          drem_r     <= '0;
          recip_r    <= '0;
          dcnt_r     <= DCW'(RW - 1);
          i_r        <= '0;
          j_r        <= '0;
          addr_r     <= '0;
          row_base_r <= '0;
          acc_r      <= '0;
          state_r    <= S_DIV;
        end

        S_DIV: begin
          drem_r  <= qbit ? PW'(rem_sh - {1'b0, denom_r}) : PW'(rem_sh);
          recip_r <= {recip_r[RW-2:0], qbit};
          if (dcnt_r == '0) begin
            state_r <= S_CELL_RD;
          end else begin
            dcnt_r <= dcnt_r - 1'b1;
          end
        end

        S_CELL_RD: state_r <= S_CELL_NUM;

        S_CELL_NUM: begin
          cur_d_r <= rd_det;
          sat_r   <= num_c >= denom_r;
          // Rounded quotient: (num * 2^16 + denom/2) / denom
          nn_r    <= {num_c[FRAC-1:0], {FRAC{1'b0}}} + NW'(denom_r >> 1);
          state_r <= S_MUL_R;
        end

        S_MUL_R: begin
          qe_r    <= prod_nr[NW+PW-1:NW];
          state_r <= S_MUL_D;
        end

        S_MUL_D: begin
          qd_r    <= {{PW{1'b0}}, qe_r} * {{PW{1'b0}}, denom_r};
          state_r <= S_FIX;
        end

        S_FIX: begin
          nv_r    <= nv_c;
          state_r <= S_MUL_DET;
        end

        S_MUL_DET: begin
          nd_r    <= nv_r * cur_d_r;
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (slot_free) begin
            acc_r     <= acc_nxt;
            o_valid_r <= 1'b1;
            o_row_r   <= i_r[2:0];
            o_col_r   <= j_r[2:0];
            o_post_r  <= nv_r;
            o_od_r    <= last_cell ? acc_nxt : '0;
            o_st_r    <= ST_OK;
            o_last_r  <= last_cell;
            if (last_cell) begin
              state_r <= S_IDLE;
            end else begin
              if (j_r == nc_eff - 1'b1) begin
                j_r        <= '0;
                i_r        <= i_r + 1'b1;
                row_base_r <= row_base_r + AW'(MAX_COLS);
                addr_r     <= row_base_r + AW'(MAX_COLS);
              end else begin
                j_r    <= j_r + 1'b1;
                addr_r <= addr_r + 1'b1;
              end
              state_r <= S_CELL_RD;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_no_detection: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.overall_detection == '0)
    else $error("overall detection given on a failed item");

  a_post_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.posterior <= ONE)
    else $error("posterior above 1.0");

  a_denom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> denom_r != '0)
    else $error("zero denominator in reciprocal");

  a_recip_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CELL_RD |-> recip_r >= RW'(ONE))
    else $error("reciprocal too small for a denominator of at most 1.0");

  a_fix_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX && !sat_r |-> rem_c < {{(PW-1){1'b0}}, denom_r, 1'b0})
    else $error("quotient estimate off by more than one");
`endif

endmodule

[design/bsgu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module bsgu_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/testbench.sv]
// Testbench for bayes_search_grid_update_top: drives loads and searches, predicts every reported
// cell in a behavioural grid model and checks each result transfer field by field.
// Depends on bsgu_pkg, bsgu_in_if, bsgu_out_if and the block's RTL.
module testbench;
  import bsgu_pkg::*;

  typedef struct {
    op_t    op;
    coord_t row;
    coord_t col;
    prob_t  prior;
    det_t   det;
  } grid_item_t;

  typedef struct {
    coord_t  row;
    coord_t  col;
    prob_t   post;
    prob_t   overall;
    status_t st;
    logic    last;
  } cell_report_t;

  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 3000;
  localparam int unsigned ITEM_TARGET = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bsgu_in_if  in_ch ();
  bsgu_out_if out_ch ();

  bayes_search_grid_update_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Behavioural copy of the grid and its registers.
  prob_t       grid_prob [64];
  det_t        grid_det [64];
  bit          grid_loaded [64];
  logic [3:0]  rows_reg;
  logic [3:0]  cols_reg;
  logic [7:0]  tol_reg;

  cell_report_t pending_reports [$];
  int           mismatches = 0;
  int unsigned  items_sent = 0;
  bit           no_idle = 1'b0;
  int           hold_requests = 0;
  int           hold_served = 0;
  int           hold_count = 0;
  int           quiet_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.cell_row = '0;
    in_ch.cell_col = '0;
    in_ch.prior_value = '0;
    in_ch.detect_value = '0;
    out_ch.ready = 1'b0;
    rows_reg = 4'd8;
    cols_reg = 4'd8;
    tol_reg = 8'd4;
    foreach (grid_loaded[k]) grid_loaded[k] = 1'b0;
  end

  function automatic int unsigned rows_active();
    return (rows_reg > 8) ? 8 : rows_reg;
  endfunction

  function automatic int unsigned cols_active();
    return (cols_reg > 8) ? 8 : cols_reg;
  endfunction

  function automatic void push_report(coord_t r, coord_t c, prob_t post, prob_t overall,
                                      status_t st, logic last);
    cell_report_t rep;
    rep.row = r;
    rep.col = c;
    rep.post = post;
    rep.overall = overall;
    rep.st = st;
    rep.last = last;
    pending_reports.push_back(rep);
  endfunction

  // Works out the reports of one accepted item and updates the grid copy.
  function automatic void predict_update(grid_item_t it);
    longint unsigned one_l = ONE;
    longint unsigned total, diff, p, d, pd, denom, num, nv, acc;
    int unsigned nr, nc, tgt, x;
    bit in_grid;
    nr = rows_active();
    nc = cols_active();
    in_grid = (it.row < nr) && (it.col < nc);
    tgt = it.row * 8 + it.col;
    if (it.op == OP_LOAD) begin
      if (!in_grid) begin
        push_report(it.row, it.col, '0, '0, ST_COORD_BAD, 1'b1);
        return;
      end
      grid_prob[tgt] = (it.prior > ONE) ? ONE : it.prior;
      grid_det[tgt] = it.det;
      grid_loaded[tgt] = 1'b1;
      push_report(it.row, it.col, grid_prob[tgt], '0, ST_OK, 1'b1);
      return;
    end
    total = 0;
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned j = 0; j < nc; j++) total += grid_prob[i * 8 + j];
    diff = (total > one_l) ? total - one_l : one_l - total;
    if (diff > tol_reg) begin
      push_report(it.row, it.col, '0, '0, ST_SUM_BAD, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned j = 0; j < nc; j++)
        if (!grid_loaded[i * 8 + j] || grid_det[i * 8 + j] == 0) begin
          push_report(it.row, it.col, '0, '0, ST_DET_BAD, 1'b1);
          return;
        end
    if (!in_grid) begin
      push_report(it.row, it.col, '0, '0, ST_COORD_BAD, 1'b1);
      return;
    end
    p = grid_prob[tgt];
    d = grid_det[tgt];
    pd = (p * d + one_l / 2) >> FRAC;
    denom = (pd >= one_l) ? 1 : one_l - pd;
    acc = 0;
    for (int unsigned i = 0; i < nr; i++)
      for (int unsigned j = 0; j < nc; j++) begin
        x = i * 8 + j;
        num = grid_prob[x];
        if (x == tgt) num = (num * (one_l - grid_det[x]) + one_l / 2) >> FRAC;
        nv = (num * one_l + denom / 2) / denom;
        if (nv > one_l) nv = one_l;
        grid_prob[x] = nv;
        acc += (nv * grid_det[x] + one_l / 2) >> FRAC;
        if (acc > one_l) acc = one_l;
        if (i == nr - 1 && j == nc - 1)
          push_report(i, j, nv, acc, ST_OK, 1'b1);
        else
          push_report(i, j, nv, '0, ST_OK, 1'b0);
      end
  endfunction

  // Offers one item, waits for its transfer and sometimes idles afterwards.
  task automatic send_item(grid_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.cell_row <= it.row;
    in_ch.cell_col <= it.col;
    in_ch.prior_value <= it.prior;
    in_ch.detect_value <= it.det;
    do @(posedge clk); while (!in_ch.ready);
    predict_update(it);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_load(coord_t r, coord_t c, prob_t prior, det_t det);
    grid_item_t it;
    it.op = OP_LOAD;
    it.row = r;
    it.col = c;
    it.prior = prior;
    it.det = det;
    send_item(it);
  endtask

  task automatic send_search(coord_t r, coord_t c);
    grid_item_t it;
    it.op = OP_SEARCH;
    it.row = r;
    it.col = c;
    it.prior = prob_t'($urandom);
    it.det = det_t'($urandom);
    send_item(it);
  endtask

  // Stops offering and waits until every predicted report has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROWS: rows_reg = value[3:0];
      REG_COLS: cols_reg = value[3:0];
      REG_TOL:  tol_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [3:0] rows, logic [3:0] cols, logic [7:0] tol);
    drain();
    write_reg(REG_ROWS, {$urandom} & 32'hFFFF_FFF0 | rows);
    write_reg(REG_COLS, {28'd0, cols});
    write_reg(REG_TOL, {24'd0, tol});
  endtask

  // Loads every cell in use so that the probabilities sum to 1.0 within the tolerance.
  task automatic fill_grid(bit with_zero_det);
    int unsigned n, k, rest, v, zero_at, nc;
    int delta;
    n = rows_active() * cols_active();
    nc = cols_active();
    rest = ONE;
    zero_at = (n > 0) ? $urandom_range(n - 1) : 0;
    for (k = 0; k < n; k++) begin
      if (k == n - 1) begin
        delta = $urandom_range(2 * tol_reg) - int'(tol_reg);
        v = (delta < 0 && rest < -delta) ? 0 : rest + delta;
      end else begin
        v = $urandom_range(0, (2 * rest) / (n - k));
        if (v > rest) v = rest;
        rest -= v;
      end
      send_load(k / nc, k % nc, v,
                (with_zero_det && k == zero_at) ? 16'd0 : det_t'($urandom_range(1, 65535)));
    end
  endtask

  task automatic test_register_extremes();
    set_grid(4'd0, 4'd15, 8'd255);
    send_load(3'd0, 3'd0, ONE, 16'd100);
    send_search(3'd0, 3'd0);
    drain();
  endtask

  task automatic test_small_grid_cases();
    set_grid(4'd1, 4'd2, 8'd0);
    send_load(3'd0, 3'd0, ONE, 16'hFFFF);
    send_load(3'd0, 3'd1, 17'd0, 16'd1);
    send_search(3'd0, 3'd0);            // denominator bottoms out at one LSB
    send_load(3'd0, 3'd0, 17'h1FFFF, 16'h8000);
    send_search(3'd0, 3'd1);            // prior saturated to 1.0, sum still 1.0
    send_load(3'd1, 3'd0, 17'd5, 16'd5);
    send_load(3'd7, 3'd7, 17'd5, 16'd5);
    send_load(3'd0, 3'd0, ONE, 16'h8000);
    send_search(3'd7, 3'd7);            // valid grid, coordinates outside
    send_search(3'd0, 3'd1);
    send_search(3'd0, 3'd0);
    send_load(3'd0, 3'd1, 17'd0, 16'd0);
    send_search(3'd0, 3'd0);            // a detection of zero is rejected
    send_load(3'd0, 3'd0, 17'h0AAAA, 16'h5555);
    send_load(3'd0, 3'd1, 17'h05556, 16'hAAAA);
    send_search(3'd0, 3'd1);
    drain();
  endtask

  task automatic test_backpressure();
    set_grid(4'd3, 4'd3, 8'd8);
    fill_grid(1'b0);
    drain();
    hold_requests++;
    repeat (3) send_search($urandom_range(0, 2), $urandom_range(0, 2));
    // The sender waits for every report before going on.
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(9);
      no_idle = (pick == 3);
      case (pick)
        0: set_grid(4'd8, 4'd8, 8'd255);
        1: set_grid(4'd15, 4'd1, 8'd0);
        default: set_grid($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 32));
      endcase
      fill_grid($urandom_range(9) == 0);
      repeat (20) begin
        pick = $urandom_range(99);
        if (pick < 70) send_search($urandom, $urandom);
        else if (pick < 85)
          send_load($urandom, $urandom, $urandom_range(0, 131071), $urandom);
        else if (pick < 95) fill_grid(1'b0);
        else fill_grid(1'b1);
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  // Result side: random stalls, one long hold on request, and the check.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_count > 0) begin
      out_ch.ready <= 1'b0;
      hold_count <= hold_count - 1;
    end else if (hold_served != hold_requests) begin
      out_ch.ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_count <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cell_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: row %0d col %0d", out_ch.out_row,
                   out_ch.out_col);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
            out_ch.posterior !== want.post || out_ch.overall_detection !== want.overall ||
            out_ch.status !== want.st || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%0d c%0d post %0d od %0d st %0d last %0d, got r%0d c%0d post %0d od %0d st %0d last %0d",
                     want.row, want.col, want.post, want.overall, want.st, want.last,
                     out_ch.out_row, out_ch.out_col, out_ch.posterior,
                     out_ch.overall_detection, out_ch.status, out_ch.last);
        end
      end
    end
  end

  // Watchdog over cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_extremes();
    test_small_grid_cases();
    test_backpressure();
    test_random_traffic();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
